FILE: rtl/core/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, widths and opcode decode for the register machine execute
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

  // datapath and field widths
  localparam int unsigned XLEN          = 64;
  localparam int unsigned IMM_W         = 32;
  localparam int unsigned FIELD_IDX_W   = 3;
  localparam int unsigned PLEN_W        = 16;
  localparam int unsigned OUT_REGS      = 6;
  localparam int unsigned NUM_REGS_DFLT = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IP_REG   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = CFG_IDX_W'(1);

  typedef enum logic {
    CMD_EXEC = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } opcode_e;

  typedef struct packed {
    logic                   cmd;
    logic [3:0]             opcode;
    logic [IMM_W-1:0]       a_field;
    logic [IMM_W-1:0]       b_field;
    logic [FIELD_IDX_W-1:0] c_field;
  } in_word_t;

  typedef struct packed {
    logic [XLEN-1:0] reg_0;
    logic [XLEN-1:0] reg_1;
    logic [XLEN-1:0] reg_2;
    logic [XLEN-1:0] reg_3;
    logic [XLEN-1:0] reg_4;
    logic [XLEN-1:0] reg_5;
    logic            halted;
    logic            bad_index;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

  // operand A names a register for all but the immediate-A forms
  function automatic logic a_is_reg(opcode_e op);
    return !(op inside {OP_SETI, OP_GTIR, OP_EQIR});
  endfunction

  // operand B names a register
  function automatic logic b_is_reg(opcode_e op);
    return op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
                      OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
  endfunction

  function automatic logic is_mul(opcode_e op);
    return op inside {OP_MULR, OP_MULI};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rme_in_if.sv
// ----------------------------------------------------------------------------
// rme_in_if
// Instruction channel: valid/ready with one instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rme_in_if import rme_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rme_out_if.sv
// ----------------------------------------------------------------------------
// rme_out_if
// Result channel: valid/ready with the register snapshot and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rme_out_if import rme_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rme_cfg_if.sv
// ----------------------------------------------------------------------------
// rme_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rme_cfg_if import rme_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rme_regmem.sv
// ----------------------------------------------------------------------------
// rme_regmem
// Register file memory: one write port, two read ports, registered read data.
// Entries read as zero until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_regmem import rme_pkg::*; #(
  parameter int unsigned NUM_REGS = NUM_REGS_DFLT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [$clog2(NUM_REGS)-1:0] waddr_i,
  input  logic [XLEN-1:0]             wdata_i,
  input  logic [$clog2(NUM_REGS)-1:0] raddr_a_i,
  input  logic [$clog2(NUM_REGS)-1:0] raddr_b_i,
  output logic [XLEN-1:0]             rdata_a_o,
  output logic [XLEN-1:0]             rdata_b_o
);

  logic [XLEN-1:0] mem_q [NUM_REGS];
  logic [XLEN-1:0] rdata_a_q;
  logic [XLEN-1:0] rdata_b_q;
  logic            vld_q [NUM_REGS];
  logic            rvld_a_q;
  logic            rvld_b_q;

  // storage and read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        vld_q[k] <= 1'b0;
      end
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_a_q <= vld_q[raddr_a_i];
      rvld_b_q <= vld_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rvld_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvld_b_q ? rdata_b_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/rme_alu.sv
// ----------------------------------------------------------------------------
// rme_alu
// Combinational result of every opcode except the multiplies.
// Operands arrive already resolved to register value or immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_alu import rme_pkg::*; (
  input  opcode_e         op_i,
  input  logic [XLEN-1:0] opa_i,
  input  logic [XLEN-1:0] opb_i,
  output logic [XLEN-1:0] res_o
);

  always_comb begin
    case (op_i)
      OP_ADDR, OP_ADDI: begin
        res_o = opa_i + opb_i;
      end
      OP_BANR, OP_BANI: begin
        res_o = opa_i & opb_i;
      end
      OP_BORR, OP_BORI: begin
        res_o = opa_i | opb_i;
      end
      OP_SETR, OP_SETI: begin
        res_o = opa_i;
      end
      OP_GTIR, OP_GTRI, OP_GTRR: begin
        res_o = XLEN'(opa_i > opb_i);
      end
      OP_EQIR, OP_EQRI, OP_EQRR: begin
        res_o = XLEN'(opa_i == opb_i);
      end
      // multiplies come from the multiplier stage
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/rme_mul.sv
// ----------------------------------------------------------------------------
// rme_mul
// Two-stage 64x64 multiplier, low half of the product. The first stage
// registers three 32x32 partial products, the second adds them.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_mul import rme_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [XLEN-1:0] opa_i,
  input  logic [XLEN-1:0] opb_i,
  output logic [XLEN-1:0] prod_o
);

  localparam int unsigned HalfW = XLEN / 2;

  logic [XLEN-1:0]  pp_ll_q;
  logic [HalfW-1:0] pp_lh_q;
  logic [HalfW-1:0] pp_hl_q;
  logic [XLEN-1:0]  prod_lh;
  logic [XLEN-1:0]  prod_hl;
  logic [HalfW-1:0] cross_sum;

  // cross products only matter in their low half
  assign prod_lh = XLEN'(opa_i[HalfW-1:0]) * XLEN'(opb_i[XLEN-1:HalfW]);
  assign prod_hl = XLEN'(opa_i[XLEN-1:HalfW]) * XLEN'(opb_i[HalfW-1:0]);

  // partial product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= XLEN'(opa_i[HalfW-1:0]) * XLEN'(opb_i[HalfW-1:0]);
      pp_lh_q <= prod_lh[HalfW-1:0];
      pp_hl_q <= prod_hl[HalfW-1:0];
    end
  end

  // combine
  assign cross_sum = pp_lh_q + pp_hl_q;
  assign prod_o    = pp_ll_q + {cross_sum, {HalfW{1'b0}}};

endmodule

`default_nettype wire

FILE: rtl/core/register_machine_execute.sv
// ----------------------------------------------------------------------------
// register_machine_execute
// Register machine execute stage with an instruction pointer bound to one of
// its registers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : write ip_register (index 0) and program_length (index 1) while
//            the block is idle; the port is always ready.
//   in_i   : one word per instruction or load command, valid/ready.
//   out_o  : one word per input word with all registers after the step,
//            the halted flag and the bad index flag.
// Path: an accepted word waits in the first stage register until its result is
//   registered in the result register; a multiply passes the multiply stage.
// Throughput: one word per cycle while out_o.ready holds; a multiply occupies
//   the second stage, so the word after it waits until the product is written.
//   The limit is the single write port of the register memory and the
//   two-stage multiplier, whose result the next word may read.
// Reset: all registers read as zero, ip_register and program_length are
//   zero, no result is pending.
// Stall: the result register holds while out_o.ready is low; one more word,
//   two if the first is a multiply, can be taken, then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module register_machine_execute import rme_pkg::*; #(
  parameter int unsigned NUM_REGS = NUM_REGS_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rme_cfg_if.sink   cfg_i,
  rme_in_if.sink    in_i,
  rme_out_if.source out_o
);

  localparam int unsigned      IdxW     = $clog2(NUM_REGS);
  localparam logic [IMM_W-1:0] NumRegsW = IMM_W'(NUM_REGS);

  // configuration
  logic [FIELD_IDX_W-1:0] ip_q;
  logic [PLEN_W-1:0]      plen_q;
  logic                   cfg_fire;
  logic                   ip_bound;
  logic [IdxW-1:0]        ip_idx;

  // architectural register view, always current
  logic [XLEN-1:0] regs_q [NUM_REGS];
  logic [XLEN-1:0] regs_d [NUM_REGS];
  logic [XLEN-1:0] ip_val;

  // first stage
  logic     s1_valid_q;
  in_word_t s1_q;
  opcode_e  s1_op;
  logic     s1_go;
  logic     s1_load;
  logic     c_ok;
  logic     a_ok;
  logic     b_ok;
  logic     a_reg;
  logic     b_reg;
  logic     halted_pre;
  logic     exec_bad;
  logic     exec_do;
  logic     load_do;
  logic     mul_do;
  logic     s1_bad;

  // memory ports and last-write forwarding
  logic [IdxW-1:0] rd_a;
  logic [IdxW-1:0] rd_b;
  logic [XLEN-1:0] rdata_a;
  logic [XLEN-1:0] rdata_b;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [XLEN-1:0] mem_wdata;
  logic            wr_en_q;
  logic [IdxW-1:0] wr_idx_q;
  logic [XLEN-1:0] wr_data_q;
  logic [XLEN-1:0] reg_a;
  logic [XLEN-1:0] reg_b;
  logic [XLEN-1:0] opa;
  logic [XLEN-1:0] opb;
  logic [XLEN-1:0] alu_res;

  // multiply stage
  logic            s2_valid_q;
  logic [IdxW-1:0] s2_c_q;
  logic [XLEN-1:0] mul_prod;
  logic            s2_fire;

  // commit
  logic            out_free;
  logic            cm_valid;
  logic            cm_we;
  logic [IdxW-1:0] cm_c;
  logic [XLEN-1:0] cm_val;
  logic            cm_inc;
  logic            cm_bad;
  logic [XLEN-1:0] inc_val;

  // result register
  logic            out_valid_q;
  logic [XLEN-1:0] out_regs_q [NUM_REGS];
  logic            out_bad_q;
  logic [XLEN-1:0] out_view [OUT_REGS];

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q   <= '0;
      plen_q <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.data.idx)
        CFG_IP_REG: begin
          ip_q <= cfg_i.data.wdata[FIELD_IDX_W-1:0];
        end
        CFG_PROG_LEN: begin
          plen_q <= cfg_i.data.wdata[PLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign ip_bound = IMM_W'(ip_q) < NumRegsW;
  assign ip_idx   = IdxW'(ip_q);
  assign ip_val   = regs_q[ip_idx];

  // handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_go;
  assign s2_fire    = s2_valid_q && out_free;

  // first stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
  end

  // operand read addresses follow the word that sits in the first stage next
  assign rd_a = in_i.ready ? IdxW'(in_i.data.a_field) : IdxW'(s1_q.a_field);
  assign rd_b = in_i.ready ? IdxW'(in_i.data.b_field) : IdxW'(s1_q.b_field);

  rme_regmem #(
    .NUM_REGS (NUM_REGS)
  ) u_regmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (rd_a),
    .raddr_b_i (rd_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // operand fetch: pointer register from the live view, else forwarded write,
  // else memory
  always_comb begin
    if (ip_bound && (s1_q.a_field == IMM_W'(ip_q))) begin
      reg_a = ip_val;
    end else if (wr_en_q && (wr_idx_q == IdxW'(s1_q.a_field))) begin
      reg_a = wr_data_q;
    end else begin
      reg_a = rdata_a;
    end
    if (ip_bound && (s1_q.b_field == IMM_W'(ip_q))) begin
      reg_b = ip_val;
    end else if (wr_en_q && (wr_idx_q == IdxW'(s1_q.b_field))) begin
      reg_b = wr_data_q;
    end else begin
      reg_b = rdata_b;
    end
  end

  // decode and checks
  assign s1_op      = opcode_e'(s1_q.opcode);
  assign s1_load    = cmd_e'(s1_q.cmd) == CMD_LOAD;
  assign a_reg      = a_is_reg(s1_op);
  assign b_reg      = b_is_reg(s1_op);
  assign c_ok       = IMM_W'(s1_q.c_field) < NumRegsW;
  assign a_ok       = s1_q.a_field < NumRegsW;
  assign b_ok       = s1_q.b_field < NumRegsW;
  assign halted_pre = !ip_bound || (ip_val >= XLEN'(plen_q));
  assign exec_bad   = !c_ok || (a_reg && !a_ok) || (b_reg && !b_ok);
  assign exec_do    = !s1_load && !halted_pre && !exec_bad;
  assign load_do    = s1_load && c_ok;
  assign mul_do     = exec_do && is_mul(s1_op);
  assign s1_bad     = s1_load ? !c_ok : (!halted_pre && exec_bad);

  assign opa = a_reg ? reg_a : XLEN'(s1_q.a_field);
  assign opb = b_reg ? reg_b : XLEN'(s1_q.b_field);

  // the first stage waits while a multiply result is still to be written
  assign s1_go = s1_valid_q && !s2_valid_q && (mul_do || out_free);

  rme_alu u_alu (
    .op_i  (s1_op),
    .opa_i (opa),
    .opb_i (opb),
    .res_o (alu_res)
  );

  rme_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (s1_go && mul_do),
    .opa_i  (opa),
    .opb_i  (opb),
    .prod_o (mul_prod)
  );

  // multiply stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_go && mul_do) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && mul_do) begin
      s2_c_q <= IdxW'(s1_q.c_field);
    end
  end

  // commit select: multiply stage or first stage
  always_comb begin
    if (s2_valid_q) begin
      cm_valid = s2_fire;
      cm_we    = s2_fire;
      cm_c     = s2_c_q;
      cm_val   = mul_prod;
      cm_inc   = s2_fire;
      cm_bad   = 1'b0;
    end else begin
      cm_valid = s1_go && !mul_do;
      cm_we    = s1_go && !mul_do && (load_do || exec_do);
      cm_c     = IdxW'(s1_q.c_field);
      cm_val   = s1_load ? XLEN'(s1_q.a_field) : alu_res;
      cm_inc   = s1_go && !mul_do && exec_do;
      cm_bad   = s1_bad;
    end
  end

  // next register view: destination write, then pointer increment
  assign inc_val = ((cm_we && (cm_c == ip_idx)) ? cm_val : ip_val) + XLEN'(1);

  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      regs_d[k] = regs_q[k];
      if (cm_we && (cm_c == IdxW'(k))) begin
        regs_d[k] = cm_val;
      end
      if (cm_inc && (ip_idx == IdxW'(k))) begin
        regs_d[k] = inc_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        regs_q[k] <= '0;
      end
    end else if (cm_valid) begin
      regs_q <= regs_d;
    end
  end

  // memory write: commit, or bring the old pointer entry up to date when the
  // pointer binding moves
  always_comb begin
    if (cm_we) begin
      mem_we    = 1'b1;
      mem_waddr = cm_c;
      mem_wdata = cm_val;
    end else begin
      mem_we    = cfg_fire && (cfg_i.data.idx == CFG_IP_REG) && ip_bound;
      mem_waddr = ip_idx;
      mem_wdata = ip_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q  <= mem_waddr;
    wr_data_q <= mem_wdata;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cm_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_valid) begin
      out_regs_q <= regs_d;
      out_bad_q  <= cm_bad;
    end
  end

  // result word, registers beyond the file read as zero
  for (genvar gk = 0; gk < OUT_REGS; gk++) begin : g_view
    if (gk < NUM_REGS) begin : g_live
      assign out_view[gk] = out_regs_q[gk];
    end else begin : g_zero
      assign out_view[gk] = '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.reg_0     = out_view[0];
  assign out_o.data.reg_1     = out_view[1];
  assign out_o.data.reg_2     = out_view[2];
  assign out_o.data.reg_3     = out_view[3];
  assign out_o.data.reg_4     = out_view[4];
  assign out_o.data.reg_5     = out_view[5];
  assign out_o.data.halted    = !ip_bound || (out_regs_q[ip_idx] >= XLEN'(plen_q));
  assign out_o.data.bad_index = out_bad_q;

endmodule

`default_nettype wire

FILE: sim/register_machine_execute_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_machine_execute_check
// Watches the configuration, instruction and result channels of the register
// machine execute block, keeps its own copy of the register file and the
// pointer binding, predicts one result word per accepted instruction word and
// compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module register_machine_execute_check import rme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rme_cfg_if          cfg_i,
  rme_in_if           in_i,
  rme_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned NREGS = NUM_REGS_DFLT;

  // machine state as predicted
  logic [XLEN-1:0]        mach_regs [NREGS];
  logic [FIELD_IDX_W-1:0] ip_sel;
  logic [PLEN_W-1:0]      prog_len;

  out_word_t   snapshot_q [$];
  out_word_t   exp_word;
  int unsigned fail_count;
  int unsigned pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  // operand A is read from the register file
  function automatic logic reads_reg_a(opcode_e op);
    case (op)
      OP_SETI, OP_GTIR, OP_EQIR: return 1'b0;
      default:                   return 1'b1;
    endcase
  endfunction

  // operand B is read from the register file
  function automatic logic reads_reg_b(opcode_e op);
    case (op)
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
      OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: return 1'b1;
      default:                            return 1'b0;
    endcase
  endfunction

  // pointer unbound or past the end of the program
  function automatic logic machine_halted();
    if (ip_sel >= NREGS) return 1'b1;
    return mach_regs[ip_sel] >= XLEN'(prog_len);
  endfunction

  function automatic out_word_t snapshot(logic bad);
    out_word_t s;
    s.reg_0     = mach_regs[0];
    s.reg_1     = mach_regs[1];
    s.reg_2     = mach_regs[2];
    s.reg_3     = mach_regs[3];
    s.reg_4     = mach_regs[4];
    s.reg_5     = mach_regs[5];
    s.halted    = machine_halted();
    s.bad_index = bad;
    return s;
  endfunction

  // run one word against the predicted state and return the snapshot after it
  function automatic out_word_t execute_word(in_word_t w);
    opcode_e         op;
    logic [XLEN-1:0] ra;
    logic [XLEN-1:0] rb;
    logic [XLEN-1:0] imm_a;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] res;
    op    = opcode_e'(w.opcode);
    imm_a = XLEN'(w.a_field);
    imm_b = XLEN'(w.b_field);
    ra    = '0;
    rb    = '0;

    // load ignores halt, opcode and operand B
    if (w.cmd == CMD_LOAD) begin
      if (w.c_field >= NREGS) return snapshot(1'b1);
      mach_regs[w.c_field] = imm_a;
      return snapshot(1'b0);
    end

    if (machine_halted()) return snapshot(1'b0);

    if ((w.c_field >= NREGS) ||
        (reads_reg_a(op) && w.a_field >= NREGS) ||
        (reads_reg_b(op) && w.b_field >= NREGS)) begin
      return snapshot(1'b1);
    end

    if (reads_reg_a(op)) ra = mach_regs[w.a_field];
    if (reads_reg_b(op)) rb = mach_regs[w.b_field];

    case (op)
      OP_ADDR: res = ra + rb;
      OP_ADDI: res = ra + imm_b;
      OP_MULR: res = ra * rb;
      OP_MULI: res = ra * imm_b;
      OP_BANR: res = ra & rb;
      OP_BANI: res = ra & imm_b;
      OP_BORR: res = ra | rb;
      OP_BORI: res = ra | imm_b;
      OP_SETR: res = ra;
      OP_SETI: res = imm_a;
      OP_GTIR: res = XLEN'(imm_a > rb);
      OP_GTRI: res = XLEN'(ra > imm_b);
      OP_GTRR: res = XLEN'(ra > rb);
      OP_EQIR: res = XLEN'(imm_a == rb);
      OP_EQRI: res = XLEN'(ra == imm_b);
      default: res = XLEN'(ra == rb);
    endcase

    // destination first, then the pointer bump
    mach_regs[w.c_field] = res;
    mach_regs[ip_sel]    = mach_regs[ip_sel] + 1'b1;
    return snapshot(1'b0);
  endfunction

  function automatic void check_field(string field_name, logic [XLEN-1:0] exp_val,
                                      logic [XLEN-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", field_name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // track handshakes, predict and compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NREGS; k++) mach_regs[k] = '0;
      ip_sel        = '0;
      prog_len      = '0;
      fail_count    = 0;
      pending_count = 0;
      snapshot_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.data.idx == CFG_IP_REG) begin
          ip_sel = cfg_i.data.wdata[FIELD_IDX_W-1:0];
        end else if (cfg_i.data.idx == CFG_PROG_LEN) begin
          prog_len = cfg_i.data.wdata[PLEN_W-1:0];
        end
      end

      if (in_i.valid && in_i.ready) snapshot_q.push_back(execute_word(in_i.data));

      if (out_i.valid && out_i.ready) begin
        if (snapshot_q.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          exp_word = snapshot_q.pop_front();
          check_field("reg_0", exp_word.reg_0, out_i.data.reg_0);
          check_field("reg_1", exp_word.reg_1, out_i.data.reg_1);
          check_field("reg_2", exp_word.reg_2, out_i.data.reg_2);
          check_field("reg_3", exp_word.reg_3, out_i.data.reg_3);
          check_field("reg_4", exp_word.reg_4, out_i.data.reg_4);
          check_field("reg_5", exp_word.reg_5, out_i.data.reg_5);
          check_field("halted", XLEN'(exp_word.halted), XLEN'(out_i.data.halted));
          check_field("bad_index", XLEN'(exp_word.bad_index), XLEN'(out_i.data.bad_index));
        end
      end
      pending_count = snapshot_q.size();
    end
  end

endmodule

FILE: sim/register_machine_execute_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_machine_execute_test
// Drives the register machine execute block with a directed program covering
// every opcode, wrapping arithmetic, bad register indexes and the halt point,
// then with random words under several pointer bindings and program lengths.
// Both sides idle at random; the result side also holds off for long spells.
// ----------------------------------------------------------------------------
module register_machine_execute_test;
  import rme_pkg::*;

  localparam int unsigned NREGS        = NUM_REGS_DFLT;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rme_cfg_if cfg_w ();
  rme_in_if  in_w ();
  rme_out_if out_w ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count  = 0;
  int unsigned tx_gap_max   = 0;
  int unsigned rx_stall_max = 0;
  bit          hold_req     = 1'b0;

  // configuration as last written, used to shape the random words
  logic [FIELD_IDX_W-1:0] tb_ip   = '0;
  logic [PLEN_W-1:0]      tb_plen = '0;

  register_machine_execute #(.NUM_REGS(NREGS)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  register_machine_execute_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_w),
    .in_i         (in_w),
    .out_i        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("register_machine_execute_test: errors");
      $finish;
    end
  end

  function automatic in_word_t instr(logic cmd, opcode_e op, logic [IMM_W-1:0] a,
                                     logic [IMM_W-1:0] b, logic [FIELD_IDX_W-1:0] c);
    in_word_t w;
    w.cmd     = cmd;
    w.opcode  = op;
    w.a_field = a;
    w.b_field = b;
    w.c_field = c;
    return w;
  endfunction

  // mostly valid register numbers, some bad ones and some wide values
  function automatic logic [IMM_W-1:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) return $urandom_range(0, NREGS - 1);
    if (r < 85) return $urandom_range(NREGS, 7);
    if (r < 90) return 32'hFFFF_FFFF;
    if (r < 95) return $urandom_range(0, 255);
    return $urandom();
  endfunction

  function automatic in_word_t make_word();
    in_word_t w;
    w.cmd     = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_EXEC;
    w.opcode  = 4'($urandom_range(0, 15));
    w.a_field = pick_operand();
    w.b_field = pick_operand();
    w.c_field = ($urandom_range(0, 99) < 95) ? 3'($urandom_range(0, NREGS - 1))
                                             : 3'($urandom_range(NREGS, 7));
    if (w.cmd == CMD_LOAD) begin
      // loads often rewind the pointer so that execution keeps going
      if (tb_ip < NREGS && $urandom_range(0, 1)) begin
        w.c_field = tb_ip;
        w.a_field = $urandom_range(0, tb_plen);
      end else if ($urandom_range(0, 1)) begin
        w.a_field = $urandom();
      end
    end
    return w;
  endfunction

  // all tasks are entered and left at a falling edge
  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_w.valid <= 1'b1;
    in_w.data  <= w;
    do @(posedge clk); while (!(in_w.valid && in_w.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_word_t cw;
    cw.idx   = idx;
    cw.wdata = value;
    cfg_w.valid <= 1'b1;
    cfg_w.data  <= cw;
    do @(posedge clk); while (!(cfg_w.valid && cfg_w.ready));
    @(negedge clk);
  endtask

  // sender stops until every result word is back
  task automatic wait_idle();
    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic configure(logic [FIELD_IDX_W-1:0] ip, logic [PLEN_W-1:0] plen);
    wait_idle();
    write_reg(CFG_IP_REG, {29'($urandom()), ip});
    write_reg(CFG_PROG_LEN, {16'($urandom()), plen});
    cfg_w.valid <= 1'b0;
    tb_ip   = ip;
    tb_plen = plen;
  endtask

  task automatic run_phase(logic [FIELD_IDX_W-1:0] ip, logic [PLEN_W-1:0] plen,
                           int unsigned tx_max, int unsigned rx_max,
                           int unsigned n_words, bit with_hold);
    configure(ip, plen);
    tx_gap_max   = tx_max;
    rx_stall_max = rx_max;
    for (int unsigned k = 0; k < n_words; k++) begin
      if (with_hold && k == n_words / 2) hold_req = 1'b1;
      send_word(make_word());
    end
  endtask

  // result side: random stalls, long hold-off on request
  initial begin : receiver
    int unsigned stall;
    out_w.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_w.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = $urandom_range(0, rx_stall_max);
        if (stall != 0) begin
          out_w.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_w.ready <= 1'b1;
      do @(posedge clk); while (!(out_w.valid && out_w.ready));
    end
  end

  initial begin : stimulus
    cfg_w.valid = 1'b0;
    cfg_w.data  = '0;
    in_w.valid  = 1'b0;
    in_w.data   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed program: pointer in r5, program ends at 100
    configure(3'd5, 16'd100);
    tx_gap_max   = 3;
    rx_stall_max = 3;
    send_word(instr(CMD_LOAD, OP_ADDR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0));
    send_word(instr(CMD_LOAD, OP_EQRR, 32'hFFFF_FFFF, 32'h0, 3'd1));
    send_word(instr(CMD_EXEC, OP_MULR, 32'd0, 32'd1, 3'd2));
    send_word(instr(CMD_EXEC, OP_MULI, 32'd2, 32'hFFFF_FFFF, 3'd3));
    // sums of the product above, which wrapped past 2^64
    send_word(instr(CMD_EXEC, OP_ADDR, 32'd3, 32'd3, 3'd4));
    send_word(instr(CMD_EXEC, OP_ADDI, 32'd4, 32'hFFFF_FFFF, 3'd4));
    send_word(instr(CMD_EXEC, OP_BANR, 32'd3, 32'd4, 3'd2));
    send_word(instr(CMD_EXEC, OP_BANI, 32'd4, 32'hF0F0_F0F0, 3'd1));
    send_word(instr(CMD_EXEC, OP_BORR, 32'd1, 32'd3, 3'd0));
    send_word(instr(CMD_EXEC, OP_BORI, 32'd2, 32'h8000_0000, 3'd2));
    // operand B of set forms is never checked
    send_word(instr(CMD_EXEC, OP_SETR, 32'd0, 32'd7, 3'd3));
    send_word(instr(CMD_EXEC, OP_SETI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1));
    send_word(instr(CMD_EXEC, OP_GTIR, 32'hFFFF_FFFF, 32'd1, 3'd2));
    send_word(instr(CMD_EXEC, OP_GTRI, 32'd1, 32'd0, 3'd3));
    send_word(instr(CMD_EXEC, OP_GTRR, 32'd0, 32'd1, 3'd4));
    send_word(instr(CMD_EXEC, OP_EQIR, 32'hFFFF_FFFF, 32'd1, 3'd0));
    send_word(instr(CMD_EXEC, OP_EQRI, 32'd1, 32'd5, 3'd2));
    send_word(instr(CMD_EXEC, OP_EQRR, 32'd1, 32'd1, 3'd3));
    // bad register numbers
    send_word(instr(CMD_EXEC, OP_ADDR, 32'd6, 32'd0, 3'd0));
    send_word(instr(CMD_EXEC, OP_ADDI, 32'd0, 32'd1, 3'd7));
    send_word(instr(CMD_EXEC, OP_MULR, 32'd1, 32'hFFFF_FFFF, 3'd2));
    send_word(instr(CMD_LOAD, OP_SETI, 32'd9, 32'd0, 3'd6));
    // write to the pointer itself, then step into the halt point
    send_word(instr(CMD_EXEC, OP_SETI, 32'd98, 32'd0, 3'd5));
    send_word(instr(CMD_EXEC, OP_ADDI, 32'd0, 32'd1, 3'd0));
    send_word(instr(CMD_EXEC, OP_ADDI, 32'd0, 32'd1, 3'd0));
    // load still works while halted
    send_word(instr(CMD_LOAD, OP_ADDR, 32'd0, 32'd0, 3'd5));

    // random phases over pointer bindings, program lengths and idling
    run_phase(3'd0, 16'hFFFF, 17, 17, 130, 1'b0);
    run_phase(3'd3, 16'd1000, 0, 0, 130, 1'b1);
    run_phase(3'd6, 16'hFFFF, 17, 0, 60, 1'b0);
    run_phase(3'd2, 16'd0, 0, 17, 60, 1'b0);
    run_phase(3'd7, 16'd500, 5, 5, 50, 1'b0);
    run_phase(3'd1, 16'hFFFF, 17, 17, 150, 1'b1);
    run_phase(3'd4, 16'd40, 3, 17, 150, 1'b0);
    run_phase(3'd5, 16'hFFFF, 17, 3, 140, 1'b0);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("register_machine_execute_test: clean");
    end else begin
      $display("register_machine_execute_test: errors");
    end
    $finish;
  end

endmodule
